>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the divider top level
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge outside reset
`define RFD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define RFD_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> hw/rtl/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared types and codes of the restoring fraction divider
// ----------------------------------------------------------------------------
package rfd_pkg;

    // width of the frac_bits register and of the clamped count carried along
    localparam int CFG_W   = 5;
    localparam int FB_W    = 6;
    localparam int QUOT_W  = 16;
    localparam int ERR_W   = 2;

    localparam logic [CFG_W-1:0] FRAC_BITS_RESET = 5'd8;

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK          = 2'd0;
    localparam logic [ERR_W-1:0] ERR_DIV_ZERO    = 2'd1;
    localparam logic [ERR_W-1:0] ERR_NOT_SMALLER = 2'd2;

    // sideband that travels with each request down the pipeline
    typedef struct packed {
        logic [ERR_W-1:0] err;
        logic             neg;
        logic [FB_W-1:0]  fb;
    } t_meta;

endpackage

>>> hw/rtl/rfd_prep.sv
// ----------------------------------------------------------------------------
// rfd_prep
// Entry stage: operand magnitudes, sign, error checks, clamped bit count
// ----------------------------------------------------------------------------
module rfd_prep #(
    parameter int OPERAND_WIDTH = 16,
    parameter int MAX_FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [OPERAND_WIDTH-1:0]    i_dividend,
    input  logic [OPERAND_WIDTH-1:0]    i_divisor,
    input  logic [rfd_pkg::CFG_W-1:0]   i_frac_bits,
    output logic                        o_ready,
    input  logic                        i_ready,
    output logic                        o_valid,
    output logic [OPERAND_WIDTH-1:0]    o_rem,
    output logic [OPERAND_WIDTH-1:0]    o_den,
    output rfd_pkg::t_meta              o_meta
);

    logic                       r_valid;
    logic [OPERAND_WIDTH-1:0]   r_rem;
    logic [OPERAND_WIDTH-1:0]   r_den;
    rfd_pkg::t_meta             r_meta;

    logic [OPERAND_WIDTH-1:0]   n_rem;
    logic [OPERAND_WIDTH-1:0]   n_den;
    rfd_pkg::t_meta             n_meta;

    // magnitudes, the most negative value maps to 2^(w-1)
    always_comb begin
        n_rem = i_dividend[OPERAND_WIDTH-1] ? (~i_dividend + 1'b1) : i_dividend;
        n_den = i_divisor[OPERAND_WIDTH-1]  ? (~i_divisor + 1'b1)  : i_divisor;
    end

    // error code, sign and clamped fraction count
    always_comb begin
        n_meta.neg = i_dividend[OPERAND_WIDTH-1] ^ i_divisor[OPERAND_WIDTH-1];
        if (n_den == '0) begin
            n_meta.err = rfd_pkg::ERR_DIV_ZERO;
        end else if (n_rem >= n_den) begin
            n_meta.err = rfd_pkg::ERR_NOT_SMALLER;
        end else begin
            n_meta.err = rfd_pkg::ERR_OK;
        end
        if (i_frac_bits == '0) begin
            n_meta.fb = rfd_pkg::FB_W'(1);
        end else if (int'(i_frac_bits) > MAX_FRAC_BITS) begin
            n_meta.fb = rfd_pkg::FB_W'(MAX_FRAC_BITS);
        end else begin
            n_meta.fb = rfd_pkg::FB_W'(i_frac_bits);
        end
    end

    assign o_ready = !r_valid || i_ready;

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rem  <= n_rem;
            r_den  <= n_den;
            r_meta <= n_meta;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_meta  = r_meta;

endmodule

>>> hw/rtl/rfd_step.sv
// ----------------------------------------------------------------------------
// rfd_step
// One restoring division step: shift, trial subtract, one quotient bit
// ----------------------------------------------------------------------------
module rfd_step #(
    parameter int OPERAND_WIDTH = 16,
    parameter int QUOT_BITS     = 17
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [OPERAND_WIDTH-1:0]    i_rem,
    input  logic [OPERAND_WIDTH-1:0]    i_den,
    input  logic [QUOT_BITS-1:0]        i_q,
    input  rfd_pkg::t_meta              i_meta,
    output logic                        o_ready,
    input  logic                        i_ready,
    output logic                        o_valid,
    output logic [OPERAND_WIDTH-1:0]    o_rem,
    output logic [OPERAND_WIDTH-1:0]    o_den,
    output logic [QUOT_BITS-1:0]        o_q,
    output rfd_pkg::t_meta              o_meta
);

    logic                       r_valid;
    logic [OPERAND_WIDTH-1:0]   r_rem;
    logic [OPERAND_WIDTH-1:0]   r_den;
    logic [QUOT_BITS-1:0]       r_q;
    rfd_pkg::t_meta             r_meta;

    logic [OPERAND_WIDTH:0]     shifted;
    logic [OPERAND_WIDTH:0]     diff;
    logic                       qbit;
    logic [OPERAND_WIDTH-1:0]   n_rem;
    logic [QUOT_BITS-1:0]       n_q;

    // trial subtract; a non-negative difference is kept, otherwise restore
    always_comb begin
        shifted = {i_rem, 1'b0};
        diff    = shifted - {1'b0, i_den};
        qbit    = !diff[OPERAND_WIDTH];
        n_rem   = qbit ? diff[OPERAND_WIDTH-1:0] : shifted[OPERAND_WIDTH-1:0];
        n_q     = {i_q[QUOT_BITS-2:0], qbit};
    end

    assign o_ready = !r_valid || i_ready;

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rem  <= n_rem;
            r_den  <= i_den;
            r_q    <= n_q;
            r_meta <= i_meta;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_q     = r_q;
    assign o_meta  = r_meta;

endmodule

>>> hw/rtl/rfd_round.sv
// ----------------------------------------------------------------------------
// rfd_round
// Two stages: align the quotient to frac_bits, then round half up,
// saturate and apply the error code; the second stage is the output register
// ----------------------------------------------------------------------------
module rfd_round #(
    parameter int QUOT_BITS = 17
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [QUOT_BITS-1:0]            i_q,
    input  rfd_pkg::t_meta                  i_meta,
    output logic                            o_ready,
    input  logic                            i_ready,
    output logic                            o_valid,
    output logic [rfd_pkg::QUOT_W-1:0]      o_quotient,
    output logic                            o_negative,
    output logic [rfd_pkg::ERR_W-1:0]       o_error
);

    localparam int SH_W = $clog2(QUOT_BITS + 1);

    logic                           r_a_valid;
    logic [QUOT_BITS-1:0]           r_a_q;
    logic [SH_W-1:0]                r_a_drop;
    rfd_pkg::t_meta                 r_a_meta;

    logic                           r_b_valid;
    logic [rfd_pkg::QUOT_W-1:0]     r_b_quot;
    logic                           r_b_neg;
    logic [rfd_pkg::ERR_W-1:0]      r_b_err;

    logic                           a_ready;
    logic                           b_ready;
    logic [SH_W-1:0]                n_a_drop;
    logic [QUOT_BITS-1:0]           n_a_q;
    logic [QUOT_BITS-1:0]           sum;
    logic [QUOT_BITS-1:0]           lim;
    logic [QUOT_BITS-1:0]           res;
    logic [rfd_pkg::QUOT_W-1:0]     n_b_quot;
    logic                           n_b_neg;

    // keep only the first fb+1 quotient bits
    always_comb begin
        n_a_drop = SH_W'(QUOT_BITS - 1) - SH_W'(i_meta.fb);
        n_a_q    = i_q >> n_a_drop;
    end

    // round half up on the guard bit, saturate at all ones of frac_bits
    always_comb begin
        sum = {1'b0, r_a_q[QUOT_BITS-1:1]} + QUOT_BITS'(r_a_q[0]);
        lim = {QUOT_BITS{1'b1}} >> (r_a_drop + 1'b1);
        res = (sum > lim) ? lim : sum;
        if (r_a_meta.err == rfd_pkg::ERR_OK) begin
            n_b_quot = rfd_pkg::QUOT_W'(res);
            n_b_neg  = r_a_meta.neg;
        end else begin
            n_b_quot = '0;
            n_b_neg  = 1'b0;
        end
    end

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    // align stage payload
    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a_q    <= n_a_q;
            r_a_drop <= n_a_drop;
            r_a_meta <= i_meta;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (b_ready && r_a_valid) begin
            r_b_quot <= n_b_quot;
            r_b_neg  <= n_b_neg;
            r_b_err  <= r_a_meta.err;
        end
    end

    assign o_valid    = r_b_valid;
    assign o_quotient = r_b_quot;
    assign o_negative = r_b_neg;
    assign o_error    = r_b_err;

endmodule

>>> hw/rtl/restoring_fraction_divider_top.sv
// Pipeline: one entry stage, one stage per quotient bit (MAX_FRAC_BITS + 1),
// two round stages.
// Throughput: one request per cycle while the output is not stalled; every stage holds its own valid bit and
// bubbles close up, so a stalled output still lets empty stages fill.
// Reset: i_rst_n synchronous, active low; clears all valid bits, frac_bits to 8.
// ----------------------------------------------------------------------------
// restoring_fraction_divider_top
// Signed fractional divider, |dividend| < |divisor|, sign-magnitude result
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module restoring_fraction_divider_top #(
    parameter int OPERAND_WIDTH = 16,
    parameter int MAX_FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration: frac_bits
    input  logic                                i_cfg_wr_en,
    input  logic [rfd_pkg::CFG_W-1:0]           i_cfg_wr_data,
    // request stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // tdata: dividend, divisor (from bit 0 up), zero padded to bytes
    input  logic [((2*OPERAND_WIDTH+7)/8)*8-1:0] i_s_tdata,
    // result stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // tdata: quotient
    output logic [rfd_pkg::QUOT_W-1:0]          o_m_tdata,
    // tuser: negative, error (from bit 0 up)
    output logic [rfd_pkg::ERR_W:0]             o_m_tuser
);

    localparam int QUOT_BITS = MAX_FRAC_BITS + 1;
    localparam int N_STEPS   = QUOT_BITS;

    logic [rfd_pkg::CFG_W-1:0]  r_frac_bits;

    logic                       stg_valid [N_STEPS+1];
    logic                       stg_ready [N_STEPS+1];
    logic [OPERAND_WIDTH-1:0]   stg_rem   [N_STEPS+1];
    logic [OPERAND_WIDTH-1:0]   stg_den   [N_STEPS+1];
    logic [QUOT_BITS-1:0]       stg_q     [N_STEPS+1];
    rfd_pkg::t_meta             stg_meta  [N_STEPS+1];

    logic                       round_ready;
    logic [rfd_pkg::QUOT_W-1:0] out_quot;
    logic                       out_neg;
    logic [rfd_pkg::ERR_W-1:0]  out_err;

    // frac_bits register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac_bits <= rfd_pkg::FRAC_BITS_RESET;
        end else if (i_cfg_wr_en) begin
            r_frac_bits <= i_cfg_wr_data;
        end
    end

    // entry stage
    rfd_prep #(
        .OPERAND_WIDTH (OPERAND_WIDTH),
        .MAX_FRAC_BITS (MAX_FRAC_BITS)
    ) u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .i_dividend  (i_s_tdata[OPERAND_WIDTH-1:0]),
        .i_divisor   (i_s_tdata[2*OPERAND_WIDTH-1:OPERAND_WIDTH]),
        .i_frac_bits (r_frac_bits),
        .o_ready     (o_s_tready),
        .i_ready     (stg_ready[0]),
        .o_valid     (stg_valid[0]),
        .o_rem       (stg_rem[0]),
        .o_den       (stg_den[0]),
        .o_meta      (stg_meta[0])
    );

    assign stg_q[0] = '0;

    // one stage per quotient bit, guard bit included
    for (genvar g = 0; g < N_STEPS; g++) begin : g_step
        rfd_step #(
            .OPERAND_WIDTH (OPERAND_WIDTH),
            .QUOT_BITS     (QUOT_BITS)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[g]),
            .i_rem   (stg_rem[g]),
            .i_den   (stg_den[g]),
            .i_q     (stg_q[g]),
            .i_meta  (stg_meta[g]),
            .o_ready (stg_ready[g]),
            .i_ready (stg_ready[g+1]),
            .o_valid (stg_valid[g+1]),
            .o_rem   (stg_rem[g+1]),
            .o_den   (stg_den[g+1]),
            .o_q     (stg_q[g+1]),
            .o_meta  (stg_meta[g+1])
        );
    end

    assign stg_ready[N_STEPS] = round_ready;

    // align, round and output register
    rfd_round #(
        .QUOT_BITS (QUOT_BITS)
    ) u_round (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (stg_valid[N_STEPS]),
        .i_q        (stg_q[N_STEPS]),
        .i_meta     (stg_meta[N_STEPS]),
        .o_ready    (round_ready),
        .i_ready    (i_m_tready),
        .o_valid    (o_m_tvalid),
        .o_quotient (out_quot),
        .o_negative (out_neg),
        .o_error    (out_err)
    );

    assign o_m_tdata = out_quot;
    assign o_m_tuser = {out_err, out_neg};

    // an error result carries no quotient and no sign
    `RFD_ASSERT(a_err_clears_result, i_clk, i_rst_n, (o_m_tvalid && out_err != rfd_pkg::ERR_OK) |-> (out_quot == '0 && !out_neg), "error result with nonzero payload")
    // with the output register empty every stage can move, so requests are taken
    `RFD_ASSERT(a_ready_when_drained, i_clk, i_rst_n, !o_m_tvalid |-> o_s_tready, "request refused while output is empty")
    // the frac_bits register only changes on a write
    `RFD_ASSERT(a_cfg_holds, i_clk, i_rst_n, !$past(i_cfg_wr_en) |-> $stable(r_frac_bits), "frac_bits changed without a write")

endmodule
